FILE: src/bspline_de_boor_evaluator_unit_assert.svh
// assertion macros shared by the evaluator modules
`ifndef BSPLINE_DE_BOOR_EVALUATOR_UNIT_ASSERT_SVH
`define BSPLINE_DE_BOOR_EVALUATOR_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BDB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/bdb_pkg.sv
package bdb_pkg;

  localparam int unsigned MaxKnots  = 128;
  localparam int unsigned MaxNodes  = 16;
  localparam int unsigned MaxDegree = 15;
  localparam int unsigned KnotAw    = $clog2(MaxKnots);
  localparam int unsigned NodeW     = $clog2(MaxNodes);
  localparam int unsigned CoefAw    = KnotAw + NodeW;
  localparam int unsigned WorkAw    = $clog2(MaxDegree + 1);

  localparam logic [1:0] KindKnot = 2'd0;
  localparam logic [1:0] KindCoef = 2'd1;
  localparam logic [1:0] KindEval = 2'd2;
  localparam logic [1:0] KindRsvd = 2'd3;

  localparam logic [1:0] RegionInside = 2'd0;
  localparam logic [1:0] RegionBelow  = 2'd1;
  localparam logic [1:0] RegionAbove  = 2'd2;

  localparam logic [1:0] RegDegree    = 2'd0;
  localparam logic [1:0] RegKnotCount = 2'd1;
  localparam logic [1:0] RegCoefCount = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         node;
    logic [6:0]         slot;
    logic signed [31:0] value;
  } bdb_in_t;

  typedef struct packed {
    logic signed [31:0] spline_value;
    logic [1:0]         region;
    logic               degenerate_gap;
  } bdb_out_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [48:0] a;
    logic [32:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [65:0] res;
  } alu_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -52'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/bdb_alu.sv
`include "bspline_de_boor_evaluator_unit_assert.svh"

module bdb_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bdb_pkg::alu_req_t req_i,
  output bdb_pkg::alu_rsp_t rsp_o
);

  logic             busy_q;
  logic             done_q;
  bdb_pkg::alu_op_e op_q;
  logic [5:0]       cnt_q;
  logic [48:0]      a_q;
  logic [32:0]      b_q;
  logic [33:0]      rem_q;
  logic [65:0]      acc_q;
  logic [33:0]      trial;
  logic             ge;

  assign trial = {rem_q[32:0], a_q[48]};
  assign ge    = trial >= {1'b0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (req_i.op == bdb_pkg::ALU_DIV) ? 6'd49 : 6'd33;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      rem_q <= '0;
      acc_q <= '0;
    end else if (busy_q) begin
      if (op_q == bdb_pkg::ALU_MUL) begin
        acc_q <= (acc_q << 1) + (b_q[32] ? {33'd0, a_q[32:0]} : 66'd0);
        b_q   <= b_q << 1;
      end else begin
        rem_q <= ge ? (trial - {1'b0, b_q}) : trial;
        acc_q <= {acc_q[64:0], ge};
        a_q   <= a_q << 1;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

  `BDB_ASSERT_IMPL(a_alu_start_idle, req_i.start, !busy_q, "alu started while busy")
  `BDB_ASSERT_IMPL(a_alu_done_idle, done_q, !busy_q, "alu done while busy")
  `BDB_ASSERT_NEXT(a_alu_start_busy, req_i.start, busy_q, "alu did not start")

endmodule

FILE: src/bdb_core.sv
`include "bspline_de_boor_evaluator_unit_assert.svh"

module bdb_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [3:0]       degree_i,
  input  logic [7:0]       knot_count_i,
  input  logic [7:0]       coef_count_i,
  input  logic             start_i,
  output logic             busy_o,
  input  bdb_pkg::bdb_in_t item_i,
  output logic             result_valid_o,
  output bdb_pkg::bdb_out_t result_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_CLR, ST_LO, ST_HI, ST_SRCH, ST_SCMP, ST_LOAD, ST_LOADW,
    ST_RTA, ST_RTB, ST_RWP, ST_RWC, ST_DIVGO, ST_DIVW, ST_MUL1, ST_MUL1W,
    ST_MUL2W, ST_FIN, ST_FINW, ST_COEF
  } state_e;

  state_e                          st_q;
  logic [3:0]                      p_q;
  logic [7:0]                      n_q, m_q;
  logic [3:0]                      row_q;
  logic signed [31:0]              x_q;
  logic [7:0]                      lo_q, hi_q;
  logic [6:0]                      mu_q;
  logic [3:0]                      j_q, k_q;
  logic signed [31:0]              ta_q, tb_q, prev_q, cur_q, a_q;
  logic signed [50:0]              p1_q;
  logic                            neg_q, gap_q;
  logic [1:0]                      region_q;
  logic                            valid_q;
  logic signed [31:0]              res_q;
  bdb_pkg::alu_req_t               alu_req_q;
  bdb_pkg::alu_rsp_t               alu_rsp;

  logic signed [31:0] knot_mem [bdb_pkg::MaxKnots];
  logic signed [31:0] coef_mem [bdb_pkg::MaxNodes * bdb_pkg::MaxKnots];
  logic signed [31:0] work_mem [bdb_pkg::MaxDegree + 1];
  logic signed [31:0] k_rd_q, c_rd_q, w_rd_q;

  logic [bdb_pkg::KnotAw-1:0] k_raddr;
  logic [bdb_pkg::KnotAw-1:0] c_ridx;
  logic [bdb_pkg::WorkAw-1:0] w_raddr;
  logic                       w_we;
  logic signed [31:0]         w_wdata;
  logic                       k_we, c_we;

  logic                       empty_dom;
  logic [7:0]                 bnd_idx, top_idx, mid, mu_max, load_idx, ti;
  logic [8:0]                 mid_sum;
  logic signed [32:0]         den, diff;
  logic [32:0]                diff_mag, den_mag;
  logic signed [33:0]         oma;
  logic [32:0]                oma_mag, prev_mag, a_mag, cur_mag;
  logic signed [66:0]         prod;
  logic signed [49:0]         quo;
  logic [7:0]                 n_cl, m_cl;

  assign n_cl = (knot_count_i < 8'd2) ? 8'd2 :
                (knot_count_i > 8'(bdb_pkg::MaxKnots)) ? 8'(bdb_pkg::MaxKnots) : knot_count_i;
  assign m_cl = (coef_count_i < 8'd1) ? 8'd1 :
                (coef_count_i > 8'(bdb_pkg::MaxKnots)) ? 8'(bdb_pkg::MaxKnots) : coef_count_i;

  assign empty_dom = {1'b0, n_q} < ({5'd0, p_q} << 1) + 9'd2;
  assign bnd_idx   = ({4'd0, p_q} < n_q - 8'd1) ? {4'd0, p_q} : n_q - 8'd1;
  assign top_idx   = n_q - {4'd0, p_q} - 8'd1;
  assign mu_max    = n_q - {4'd0, p_q} - 8'd2;
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[8:1];
  assign ti        = {1'b0, mu_q} - {4'd0, p_q} + {4'd0, j_q};
  assign load_idx  = (ti >= m_q) ? m_q - 8'd1 : ti;

  assign diff     = $signed({x_q[31], x_q}) - $signed({ta_q[31], ta_q});
  assign den      = $signed({tb_q[31], tb_q}) - $signed({ta_q[31], ta_q});
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign den_mag  = den[32] ? 33'(-den) : 33'(den);
  assign oma      = 34'sd65536 - $signed({{2{a_q[31]}}, a_q});
  assign oma_mag  = oma[33] ? 33'(-oma) : 33'(oma);
  assign prev_mag = prev_q[31] ? 33'(-$signed({prev_q[31], prev_q})) : {1'b0, prev_q};
  assign a_mag    = a_q[31] ? 33'(-$signed({a_q[31], a_q})) : {1'b0, a_q};
  assign cur_mag  = cur_q[31] ? 33'(-$signed({cur_q[31], cur_q})) : {1'b0, cur_q};
  assign prod     = neg_q ? -$signed({1'b0, alu_rsp.res}) : $signed({1'b0, alu_rsp.res});
  assign quo      = neg_q ? -$signed({1'b0, alu_rsp.res[48:0]})
                          : $signed({1'b0, alu_rsp.res[48:0]});

  assign k_we = (st_q == ST_IDLE) && start_i && (item_i.kind == bdb_pkg::KindKnot);
  assign c_we = (st_q == ST_IDLE) && start_i && (item_i.kind == bdb_pkg::KindCoef);

  always_comb begin
    k_raddr = '0;
    c_ridx  = '0;
    w_raddr = '0;
    w_we    = 1'b0;
    w_wdata = c_rd_q;
    case (st_q)
      ST_CHK:   k_raddr = empty_dom ? bnd_idx[6:0] : {3'd0, p_q};
      ST_CLR:   c_ridx  = (x_q < k_rd_q) ? 7'd0 : 7'(m_q - 8'd1);
      ST_LO:    k_raddr = top_idx[6:0];
      ST_HI:    c_ridx  = 7'(m_q - 8'd1);
      ST_SRCH:  k_raddr = mid[6:0];
      ST_LOAD:  c_ridx  = load_idx[6:0];
      ST_LOADW: begin
        w_raddr = j_q;
        w_we    = 1'b1;
      end
      ST_RTA:   k_raddr = ti[6:0];
      ST_RTB:   k_raddr = 7'(ti + {4'd0, k_q});
      ST_RWP:   w_raddr = j_q - 4'd1;
      ST_RWC:   w_raddr = j_q;
      ST_MUL2W: begin
        w_raddr = j_q;
        w_we    = alu_rsp.done;
        w_wdata = bdb_pkg::sat32(52'(p1_q) + 52'($signed(prod[66:16])));
      end
      ST_FIN:   w_raddr = p_q;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (k_we) begin
      knot_mem[item_i.slot] <= item_i.value;
    end
    k_rd_q <= knot_mem[k_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      coef_mem[{item_i.node, item_i.slot}] <= item_i.value;
    end
    c_rd_q <= coef_mem[{row_q, c_ridx}];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      work_mem[w_raddr] <= w_wdata;
    end
    w_rd_q <= work_mem[w_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q            <= ST_IDLE;
      valid_q         <= 1'b0;
      alu_req_q.start <= 1'b0;
    end else begin
      valid_q         <= 1'b0;
      alu_req_q.start <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (start_i && item_i.kind == bdb_pkg::KindEval) begin
            p_q      <= degree_i;
            n_q      <= n_cl;
            m_q      <= m_cl;
            row_q    <= item_i.node;
            x_q      <= item_i.value;
            gap_q    <= 1'b0;
            region_q <= bdb_pkg::RegionInside;
            st_q     <= ST_CHK;
          end
        end
        ST_CHK: st_q <= empty_dom ? ST_CLR : ST_LO;
        ST_CLR: begin
          region_q <= (x_q < k_rd_q) ? bdb_pkg::RegionBelow : bdb_pkg::RegionAbove;
          st_q     <= ST_COEF;
        end
        ST_LO: begin
          if (x_q < k_rd_q) begin
            region_q <= bdb_pkg::RegionBelow;
            st_q     <= ST_COEF;
          end else begin
            st_q <= ST_HI;
          end
        end
        ST_HI: begin
          if (x_q >= k_rd_q) begin
            region_q <= bdb_pkg::RegionAbove;
            st_q     <= ST_COEF;
          end else begin
            lo_q <= 8'd0;
            hi_q <= n_q - 8'd1;
            st_q <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (hi_q - lo_q > 8'd1) begin
            st_q <= ST_SCMP;
          end else begin
            mu_q <= (lo_q < {4'd0, p_q}) ? {3'd0, p_q} :
                    (lo_q > mu_max) ? mu_max[6:0] : lo_q[6:0];
            j_q  <= 4'd0;
            st_q <= ST_LOAD;
          end
        end
        ST_SCMP: begin
          if (k_rd_q <= x_q) begin
            lo_q <= mid;
          end else begin
            hi_q <= mid;
          end
          st_q <= ST_SRCH;
        end
        ST_LOAD: st_q <= ST_LOADW;
        ST_LOADW: begin
          if (j_q == p_q) begin
            if (p_q == 4'd0) begin
              st_q <= ST_FIN;
            end else begin
              k_q  <= p_q;
              st_q <= ST_RTA;
            end
          end else begin
            j_q  <= j_q + 4'd1;
            st_q <= ST_LOAD;
          end
        end
        ST_RTA: st_q <= ST_RTB;
        ST_RTB: begin
          ta_q <= k_rd_q;
          st_q <= ST_RWP;
        end
        ST_RWP: begin
          tb_q <= k_rd_q;
          st_q <= ST_RWC;
        end
        ST_RWC: begin
          prev_q <= w_rd_q;
          st_q   <= ST_DIVGO;
        end
        ST_DIVGO: begin
          cur_q <= w_rd_q;
          if (den == 33'sd0) begin
            a_q   <= '0;
            gap_q <= 1'b1;
            st_q  <= ST_MUL1;
          end else begin
            alu_req_q.start <= 1'b1;
            alu_req_q.op    <= bdb_pkg::ALU_DIV;
            alu_req_q.a     <= {diff_mag, 16'd0};
            alu_req_q.b     <= den_mag;
            neg_q           <= diff[32] ^ den[32];
            st_q            <= ST_DIVW;
          end
        end
        ST_DIVW: begin
          if (alu_rsp.done) begin
            a_q  <= bdb_pkg::sat32(52'(quo));
            st_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          alu_req_q.start <= 1'b1;
          alu_req_q.op    <= bdb_pkg::ALU_MUL;
          alu_req_q.a     <= {16'd0, oma_mag};
          alu_req_q.b     <= prev_mag;
          neg_q           <= oma[33] ^ prev_q[31];
          st_q            <= ST_MUL1W;
        end
        ST_MUL1W: begin
          if (alu_rsp.done) begin
            p1_q            <= prod[66:16];
            alu_req_q.start <= 1'b1;
            alu_req_q.op    <= bdb_pkg::ALU_MUL;
            alu_req_q.a     <= {16'd0, a_mag};
            alu_req_q.b     <= cur_mag;
            neg_q           <= a_q[31] ^ cur_q[31];
            st_q            <= ST_MUL2W;
          end
        end
        ST_MUL2W: begin
          if (alu_rsp.done) begin
            if (j_q == p_q - k_q + 4'd1) begin
              if (k_q == 4'd1) begin
                st_q <= ST_FIN;
              end else begin
                k_q  <= k_q - 4'd1;
                j_q  <= p_q;
                st_q <= ST_RTA;
              end
            end else begin
              j_q  <= j_q - 4'd1;
              st_q <= ST_RTA;
            end
          end
        end
        ST_FIN: st_q <= ST_FINW;
        ST_FINW: begin
          res_q   <= w_rd_q;
          valid_q <= 1'b1;
          st_q    <= ST_IDLE;
        end
        ST_COEF: begin
          res_q   <= c_rd_q;
          gap_q   <= 1'b0;
          valid_q <= 1'b1;
          st_q    <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  bdb_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req_q),
    .rsp_o  (alu_rsp)
  );

  assign busy_o                  = st_q != ST_IDLE;
  assign result_valid_o          = valid_q;
  assign result_o.spline_value   = res_q;
  assign result_o.region         = region_q;
  assign result_o.degenerate_gap = gap_q;

  `BDB_ASSERT_IMPL(a_res_when_idle, valid_q, !busy_o, "result beat while busy")
  `BDB_ASSERT_NEXT(a_res_single, valid_q, !valid_q, "result beat longer than one cycle")
  `BDB_ASSERT_NEXT(a_eval_busy, start_i && !busy_o && item_i.kind == bdb_pkg::KindEval,
                   busy_o, "evaluation accepted without going busy")

endmodule

FILE: src/bspline_de_boor_evaluator_unit.sv
// B-spline evaluator (de Boor) over a shared knot table and per-node coefficient rows.
// Command channel: an item is taken on a rising edge with start high and busy low.
// Knot and coefficient writes produce no result and leave busy low.
// An evaluate item raises busy until its result; the result beat is on result_o for
// one cycle with result_valid_o high, and busy drops in that same cycle.
// Clamped evaluations compare x with the boundary knots and return an end coefficient.
// Inside the domain an evaluation runs a binary knot search, loads p+1 coefficients
// and does p*(p+1)/2 recurrence steps, each a 49-bit division (skipped when the knot
// gap is zero) and two 33-bit multiplications on the single shared bit-serial
// arithmetic unit, plus registered memory reads of two knots and two work points.
// Configuration: APB, degree at 0x0, knot_count at 0x4, coef_count at 0x8;
// pready is always high, writes land on the access cycle.
// Reset returns the control to idle and the registers to 3, 8 and 4; the tables
// hold nothing valid until written. The receiver cannot stall results.
module bspline_de_boor_evaluator_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  bdb_pkg::bdb_in_t  item_i,
  output logic              result_valid_o,
  output bdb_pkg::bdb_out_t result_o
);

  logic [3:0] degree_q;
  logic [7:0] knot_count_q;
  logic [7:0] coef_count_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q     <= 4'd3;
      knot_count_q <= 8'd8;
      coef_count_q <= 8'd4;
    end else if (wr_en) begin
      case (paddr[3:2])
        bdb_pkg::RegDegree:    degree_q     <= pwdata[3:0];
        bdb_pkg::RegKnotCount: knot_count_q <= pwdata[7:0];
        bdb_pkg::RegCoefCount: coef_count_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bdb_pkg::RegDegree:    prdata = {28'd0, degree_q};
      bdb_pkg::RegKnotCount: prdata = {24'd0, knot_count_q};
      bdb_pkg::RegCoefCount: prdata = {24'd0, coef_count_q};
      default:               prdata = 32'd0;
    endcase
  end

  bdb_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .degree_i       (degree_q),
    .knot_count_i   (knot_count_q),
    .coef_count_i   (coef_count_q),
    .start_i        (start),
    .busy_o         (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: sim/bdb_checker.sv
`timescale 1ns / 1ps

module bdb_checker
  import bdb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     psel,
  input  logic     penable,
  input  logic     pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  input  logic     pready,
  input  logic     start,
  input  logic     busy,
  input  bdb_in_t  item_i,
  input  logic     result_valid_o,
  input  bdb_out_t result_o,
  output int       errors,
  output int       waiting
);

  longint   knot_mem [MaxKnots];
  longint   coef_mem [MaxNodes][MaxKnots];
  longint   pts [MaxDegree + 1];
  logic [3:0] deg_q;
  logic [7:0] kc_q;
  logic [7:0] cc_q;
  bdb_out_t spline_q [$];

  function automatic longint clamp32(longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    if (v < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic longint coef_get(int row, int idx, int m);
    int i;
    i = (idx >= m) ? m - 1 : idx;
    return coef_mem[row][i];
  endfunction

  function automatic bdb_out_t spline_predict(bdb_in_t it);
    int p, n, m, row, lo, hi, mid, mu, k, j, ti, b;
    longint x, den, a, res;
    bdb_out_t o;
    p = deg_q;
    n = (kc_q < 2) ? 2 : (kc_q > MaxKnots) ? MaxKnots : kc_q;
    m = (cc_q < 1) ? 1 : (cc_q > MaxKnots) ? MaxKnots : cc_q;
    row = it.node;
    x = it.value;
    o.degenerate_gap = 1'b0;
    o.region = RegionInside;
    if (n < 2 * p + 2) begin
      b = (p < n - 1) ? p : n - 1;
      if (x < knot_mem[b]) begin
        o.region = RegionBelow;
        res = coef_get(row, 0, m);
      end else begin
        o.region = RegionAbove;
        res = coef_get(row, m - 1, m);
      end
    end else if (x < knot_mem[p]) begin
      o.region = RegionBelow;
      res = coef_get(row, 0, m);
    end else if (x >= knot_mem[n - p - 1]) begin
      o.region = RegionAbove;
      res = coef_get(row, m - 1, m);
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (knot_mem[mid] <= x) lo = mid;
        else hi = mid;
      end
      mu = lo;
      if (mu < p) mu = p;
      if (mu > n - p - 2) mu = n - p - 2;
      for (j = 0; j <= p; j++) pts[j] = coef_get(row, mu - p + j, m);
      for (k = p; k > 0; k--) begin
        for (j = p; j > p - k; j--) begin
          ti = mu - p + j;
          den = knot_mem[ti + k] - knot_mem[ti];
          if (den == 0) begin
            a = 0;
            o.degenerate_gap = 1'b1;
          end else begin
            a = clamp32(((x - knot_mem[ti]) * 65536) / den);
          end
          pts[j] = clamp32((((65536 - a) * pts[j - 1]) >>> 16) + ((a * pts[j]) >>> 16));
        end
      end
      res = pts[p];
    end
    o.spline_value = res[31:0];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bdb_out_t want;
    int nerr;
    nerr = 0;
    if (!rst_ni) begin
      deg_q = 4'd3;
      kc_q = 8'd8;
      cc_q = 8'd4;
      spline_q.delete();
      errors <= 0;
      waiting <= 0;
    end else begin
      if (result_valid_o) begin
        if (spline_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, result_o);
          nerr++;
        end else begin
          want = spline_q.pop_front();
          if (want.spline_value !== result_o.spline_value) begin
            $display("%0t: spline_value expected %h actual %h", $time,
                     want.spline_value, result_o.spline_value);
            nerr++;
          end
          if (want.region !== result_o.region) begin
            $display("%0t: region expected %0d actual %0d", $time, want.region,
                     result_o.region);
            nerr++;
          end
          if (want.degenerate_gap !== result_o.degenerate_gap) begin
            $display("%0t: degenerate_gap expected %0b actual %0b", $time,
                     want.degenerate_gap, result_o.degenerate_gap);
            nerr++;
          end
        end
      end
      if (start && !busy) begin
        case (item_i.kind)
          KindKnot: knot_mem[item_i.slot] = item_i.value;
          KindCoef: coef_mem[item_i.node][item_i.slot] = item_i.value;
          KindEval: spline_q.push_back(spline_predict(item_i));
          default: ;
        endcase
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegDegree:    deg_q = pwdata[3:0];
          RegKnotCount: kc_q = pwdata[7:0];
          RegCoefCount: cc_q = pwdata[7:0];
          default: ;
        endcase
      end
      errors <= errors + nerr;
      waiting <= spline_q.size();
    end
  end

endmodule

FILE: sim/bspline_de_boor_evaluator_unit_tb.sv
`timescale 1ns / 1ps

module bspline_de_boor_evaluator_unit_tb;
  import bdb_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       psel = 1'b0;
  logic       penable = 1'b0;
  logic       pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic       pready;
  logic       start = 1'b0;
  logic       busy;
  bdb_in_t    item_i = '0;
  logic       result_valid_o;
  bdb_out_t   result_o;
  int         errors;
  int         waiting;

  longint knot_sh [MaxKnots];
  int     p_use, n_use;
  int     node_a, node_b;
  bit     idle_en;
  int     items_sent, evals_sent;

  always #6 clk_i = ~clk_i;

  bspline_de_boor_evaluator_unit uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .item_i, .result_valid_o, .result_o
  );

  bdb_checker chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .start, .busy, .item_i, .result_valid_o, .result_o, .errors, .waiting
  );

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send(logic [1:0] kind, int node, int slot, longint value);
    start <= 1'b1;
    item_i <= '{kind: kind, node: node[3:0], slot: slot[6:0], value: value[31:0]};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (kind == KindEval) evals_sent++;
    if (idle_en && $urandom_range(99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic setup_phase(int deg, int kc, int cc, int na, int nb);
    longint t;
    int m;
    drain();
    reg_write(RegDegree, deg);
    reg_write(RegKnotCount, kc);
    reg_write(RegCoefCount, cc);
    p_use = deg;
    n_use = (kc < 2) ? 2 : (kc > MaxKnots) ? MaxKnots : kc;
    m = (cc < 1) ? 1 : (cc > MaxKnots) ? MaxKnots : cc;
    node_a = na;
    node_b = nb;
    t = longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
    for (int i = 0; i < n_use; i++) begin
      knot_sh[i] = t;
      send(KindKnot, 0, i, t);
      if ($urandom_range(9) != 0) t += $urandom_range(1024, 3 * 65536);
    end
    for (int j = 0; j < m; j++) begin
      send(KindCoef, na, j, $signed($urandom));
      send(KindCoef, nb, j, $signed($urandom));
    end
  endtask

  task automatic random_eval();
    longint lo, hi, x;
    int node;
    node = $urandom_range(1) ? node_a : node_b;
    lo = knot_sh[0] - 65536;
    hi = knot_sh[n_use - 1] + 65536;
    case ($urandom_range(9))
      0, 1: x = $signed($urandom);
      2: x = knot_sh[$urandom_range(n_use - 1)];
      default: x = lo + longint'($urandom) % (hi - lo + 1);
    endcase
    send(KindEval, node, 0, x);
  endtask

  task automatic random_items(int count);
    int r, slot;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        slot = $urandom_range(MaxKnots - 1);
        if (slot < n_use) begin
          knot_sh[slot] += longint'($urandom_range(65535)) - 32768;
          send(KindKnot, $urandom_range(15), slot, knot_sh[slot]);
        end else begin
          send(KindKnot, $urandom_range(15), slot, $signed($urandom));
        end
      end else if (r < 20) begin
        send(KindCoef, $urandom_range(1) ? node_a : node_b, $urandom_range(MaxKnots - 1),
             $signed($urandom));
      end else if (r < 22) begin
        send(KindRsvd, $urandom_range(15), $urandom_range(127), $signed($urandom));
      end else begin
        random_eval();
      end
    end
  endtask

  initial begin
    items_sent = 0;
    evals_sent = 0;
    idle_en = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    setup_phase(3, 8, 4, 0, 15);
    send(KindEval, 0, 0, 32'sh80000000);
    send(KindEval, 15, 0, 32'sh7fffffff);
    send(KindEval, 0, 0, knot_sh[3]);
    send(KindEval, 15, 0, knot_sh[4]);
    send(KindEval, 0, 0, knot_sh[4] - 1);
    send(KindCoef, 15, 0, 32'sh7fffffff);
    send(KindCoef, 15, 3, 32'sh80000000);
    send(KindEval, 15, 0, knot_sh[3]);
    send(KindRsvd, 15, 127, 32'sh7fffffff);
    send(KindKnot, 15, 127, 32'sh80000000);
    send(KindCoef, 15, 127, 32'sh7fffffff);
    // unsorted knots so that a gap in the recurrence is zero
    knot_sh[3] = knot_sh[4] - 65536;
    knot_sh[1] = knot_sh[4];
    send(KindKnot, 0, 3, knot_sh[3]);
    send(KindKnot, 0, 1, knot_sh[1]);
    send(KindEval, 0, 0, knot_sh[3]);
    send(KindEval, 15, 0, knot_sh[3] + 100);
    random_items(50);

    setup_phase(0, 0, 0, 1, 14);
    random_items(30);

    idle_en = 1'b0;
    setup_phase(1, 6, 5, 2, 9);
    random_items(50);
    idle_en = 1'b1;

    setup_phase(7, 10, 3, 0, 15);
    random_items(25);

    setup_phase(5, 16, 9, 3, 12);
    random_items(30);

    setup_phase(2, 12, 7, 6, 10);
    random_items(25);
    drain();
    random_items(30);

    setup_phase(15, 255, 40, 4, 11);
    repeat (8) random_eval();

    drain();
    $display("sent %0d items, %0d evaluations, over seven register settings", items_sent,
             evals_sent);
    $display("degrees 0 to 15, clamped, inside and empty-domain cases");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
